// File: rtl/core/swxd_pkg.sv
// Package for the sync word / XOR checksum deframer.
// Parse phase type, frame status codes, sync word bytes and default settings.
// No dependencies.
package swxd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LEN   = 2'd1,
        PH_BODY  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    typedef logic [1:0] status_t;
    localparam status_t ST_IN_PROGRESS = 2'd0;
    localparam status_t ST_GOOD        = 2'd1;
    localparam status_t ST_BAD         = 2'd2;
    localparam status_t ST_REJECTED    = 2'd3;

    localparam int BODY_LENGTH_BITS_DEF = 16;
    localparam logic [15:0] MAX_BODY_LENGTH_RESET = 16'd4096;
    localparam logic [31:0] MIN_BODY_LENGTH = 32'd2;

    // sync word 02 55 53 50, in arrival order
    function automatic logic [7:0] sync_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h02;
            2'd1:    b = 8'h55;
            2'd2:    b = 8'h53;
            2'd3:    b = 8'h50;
            default: b = 8'h02;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/sync_word_xor_deframer.sv
// Sync word / length framing deframer with XOR checksum check.
// Depends on swxd_pkg (phase type, status codes, sync word, defaults).
//
// Takes one received word (byte) per cycle on the rx channel and can accept a new
// word in every cycle while rx_ready is high: all parsing is one pass of compare,
// shift and XOR logic from the state registers into a single result register. A
// word's result, if any, is on the res channel in the cycle after it is accepted.
// The result register is the only thing that throttles input: rx_ready drops only
// while a result is held there and res_ready is low. Body words come out one per
// cycle when res is not stalled; the checksum word closes the frame with status,
// frame type and length L+1, and a rejected length gives one closing result with
// status 3. max_body_length is set by cfg_we/cfg_data, capped at 2^BODY_LENGTH_BITS-1.
module sync_word_xor_deframer #(
    parameter int BODY_LENGTH_BITS = swxd_pkg::BODY_LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  out_byte,
    output logic        is_first,
    output logic        is_last,
    output logic [16:0] frame_length,
    output logic [15:0] frame_type,
    output logic [1:0]  frame_status
);

    localparam logic [32:0] CAP_WIDE = (33'd1 << BODY_LENGTH_BITS) - 33'd1;
    localparam logic [31:0] BODY_CAP = CAP_WIDE[31:0];

    logic [15:0]                 max_len_reg;
    swxd_pkg::phase_t            phase_reg, phase_next;
    logic [1:0]                  sync_reg, sync_next;
    logic [31:0]                 len_reg, len_next;
    logic [1:0]                  cnt_reg, cnt_next;
    logic [BODY_LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [7:0]                  xor_reg, xor_next;
    logic [15:0]                 type_reg, type_next;

    logic        res_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        is_first_reg;
    logic        is_last_reg;
    logic [16:0] frame_length_reg;
    logic [15:0] frame_type_reg;
    logic [1:0]  frame_status_reg;

    logic        rx_fire;
    logic        emit;
    logic [7:0]  e_byte;
    logic        e_first;
    logic        e_last;
    logic [16:0] e_length;
    logic [15:0] e_type;
    logic [1:0]  e_status;
    logic [31:0] len_shifted;
    logic [31:0] limit;

    assign rx_ready    = !res_valid_reg || res_ready;
    assign rx_fire     = rx_valid && rx_ready;
    assign len_shifted = {len_reg[23:0], rx_byte};
    assign limit       = ({16'd0, max_len_reg} > BODY_CAP) ? BODY_CAP : {16'd0, max_len_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        sync_next   = sync_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        remain_next = remain_reg;
        xor_next    = xor_reg;
        type_next   = type_reg;
        emit        = 1'b0;
        e_byte      = 8'd0;
        e_first     = 1'b0;
        e_last      = 1'b0;
        e_length    = 17'd0;
        e_type      = 16'd0;
        e_status    = swxd_pkg::ST_IN_PROGRESS;
        if (rx_fire)
        begin
            case (phase_reg)
                swxd_pkg::PH_HUNT:
                begin
                    if (rx_byte == swxd_pkg::sync_byte(sync_reg))
                    begin
                        if (sync_reg == 2'd3)
                        begin
                            sync_next  = 2'd0;
                            phase_next = swxd_pkg::PH_LEN;
                            len_next   = 32'd0;
                            cnt_next   = 2'd0;
                        end
                        else
                        begin
                            sync_next = sync_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        // a stray 02 can still start a new match
                        sync_next = (rx_byte == swxd_pkg::sync_byte(2'd0)) ? 2'd1 : 2'd0;
                    end
                end
                swxd_pkg::PH_LEN:
                begin
                    len_next = len_shifted;
                    if (cnt_reg != 2'd3)
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                    else
                    begin
                        cnt_next = 2'd0;
                        if (len_shifted < swxd_pkg::MIN_BODY_LENGTH || len_shifted > limit)
                        begin
                            phase_next = swxd_pkg::PH_HUNT;
                            sync_next  = 2'd0;
                            emit       = 1'b1;
                            e_last     = 1'b1;
                            e_status   = swxd_pkg::ST_REJECTED;
                            e_length   = (len_shifted >= 32'h0001_FFFF) ? 17'h1_FFFF
                                       : len_shifted[16:0] + 17'd1;
                        end
                        else
                        begin
                            remain_next = len_shifted[BODY_LENGTH_BITS-1:0];
                            xor_next    = 8'd0;
                            type_next   = 16'd0;
                            phase_next  = swxd_pkg::PH_BODY;
                        end
                    end
                end
                swxd_pkg::PH_BODY:
                begin
                    // cnt_reg counts body position up to 2 (type bytes)
                    if (cnt_reg < 2'd2)
                    begin
                        type_next = {type_reg[7:0], rx_byte};
                        cnt_next  = cnt_reg + 2'd1;
                    end
                    xor_next    = xor_reg ^ rx_byte;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == {{(BODY_LENGTH_BITS-1){1'b0}}, 1'b1})
                    begin
                        phase_next = swxd_pkg::PH_CHECK;
                    end
                    emit    = 1'b1;
                    e_byte  = rx_byte;
                    e_first = (cnt_reg == 2'd0);
                end
                swxd_pkg::PH_CHECK:
                begin
                    phase_next = swxd_pkg::PH_HUNT;
                    sync_next  = 2'd0;
                    cnt_next   = 2'd0;
                    emit       = 1'b1;
                    e_byte     = rx_byte;
                    e_last     = 1'b1;
                    e_length   = len_reg[16:0] + 17'd1;
                    e_type     = type_reg;
                    e_status   = (rx_byte == xor_reg) ? swxd_pkg::ST_GOOD : swxd_pkg::ST_BAD;
                end
                default:
                begin
                    phase_next = swxd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= swxd_pkg::MAX_BODY_LENGTH_RESET;
            phase_reg     <= swxd_pkg::PH_HUNT;
            sync_reg      <= 2'd0;
            len_reg       <= 32'd0;
            cnt_reg       <= 2'd0;
            remain_reg    <= '0;
            xor_reg       <= 8'd0;
            type_reg      <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_data;
            end
            phase_reg  <= phase_next;
            sync_reg   <= sync_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            remain_reg <= remain_next;
            xor_reg    <= xor_next;
            type_reg   <= type_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg     <= e_byte;
            is_first_reg     <= e_first;
            is_last_reg      <= e_last;
            frame_length_reg <= e_length;
            frame_type_reg   <= e_type;
            frame_status_reg <= e_status;
        end
    end

    assign res_valid    = res_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_first     = is_first_reg;
    assign is_last      = is_last_reg;
    assign frame_length = frame_length_reg;
    assign frame_type   = frame_type_reg;
    assign frame_status = frame_status_reg;

`ifndef SYNTHESIS
    // a closing result always carries a final status
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && is_last_reg |-> frame_status_reg != swxd_pkg::ST_IN_PROGRESS)
        else $error("closing result with in-progress status");

    // body words carry no frame summary
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !is_last_reg |->
            frame_status_reg == swxd_pkg::ST_IN_PROGRESS && frame_length_reg == 17'd0)
        else $error("body word with summary fields set");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && is_first_reg |-> !is_last_reg)
        else $error("word marked both first and last");

    // the body counter never runs out while still in the body phase
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == swxd_pkg::PH_BODY |-> remain_reg != '0)
        else $error("body phase with zero words remaining");

    // a checksum word always returns to hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_fire && phase_reg == swxd_pkg::PH_CHECK |=> phase_reg == swxd_pkg::PH_HUNT)
        else $error("no return to hunting after checksum");
`endif

endmodule
